FILE: hdl/slc_pkg.sv
// Shared types, codes and saturation helper for the spline layer classifier.
package slc_pkg;

	localparam int CoefW = 32;

	typedef enum logic [1:0] {
		OP_WR_KNOT = 2'd0,
		OP_WR_COEF = 2'd1,
		OP_WR_DENS = 2'd2,
		OP_QUERY   = 2'd3
	} opcode_t;

	typedef enum logic [0:0] {
		REG_BOUNDARY_COUNT = 1'b0,
		REG_KNOT_COUNT     = 1'b1
	} reg_index_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_K0,
		ST_K0W,
		ST_SCAN,
		ST_COEF,
		ST_CWAIT,
		ST_MUL,
		ST_ADD,
		ST_CMP,
		ST_DENS,
		ST_DWAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic add;
	} horner_ctl_t;

	function automatic logic signed [CoefW-1:0] sat32(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sh0000_0000_7FFF_FFFF;
		lo = -64'sh0000_0000_8000_0000;
		if (v > hi) begin
			return 32'sh7FFF_FFFF;
		end else if (v < lo) begin
			return 32'sh8000_0000;
		end
		return CoefW'(v);
	endfunction

endpackage

FILE: hdl/slc_ram.sv
// Generic simple dual-port RAM with registered read.
module slc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: hdl/slc_horner.sv
// Horner multiply-add unit: one registered product, then floor shift, add and saturate.
module slc_horner (
	input  logic                         clk,
	input  slc_pkg::horner_ctl_t         ctl,
	input  logic signed [31:0]           a_in,
	input  logic signed [31:0]           t_in,
	input  logic [95:0]                  coefs,
	output logic signed [31:0]           v
);
	import slc_pkg::*;

	logic signed [31:0] v_q;
	logic signed [31:0] t_q;
	logic [95:0]        cf_q;
	logic signed [63:0] prod_s1;
	logic signed [63:0] sum;

	assign sum = (prod_s1 >>> 16) + 64'($signed(cf_q[95:64]));
	assign v   = v_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			v_q  <= a_in;
			t_q  <= t_in;
			cf_q <= coefs;
		end else if (ctl.add) begin
			v_q  <= sat32(sum);
			cf_q <= {cf_q[63:0], 32'd0};
		end
		if (ctl.mul) begin
			prod_s1 <= 64'(v_q) * 64'(t_q);
		end
	end
endmodule

FILE: hdl/spline_layer_classifier.sv
// Top level: stored spline tables, knot scan, Horner evaluation and layer walk.
//
//  channel | signals                                   | role
//  in      | in_valid, in_ready, opcode..density_value | write or query item
//  out     | out_valid, out_ready, layer_found/density | one result per item
//  cfg     | cfg_we, cfg_index, cfg_data               | register write
//
// Write items go straight to the final state. A query walks B boundaries, each
// a scan of S knot reads (at most knot_count-1) and Horner; the one-read-per-cycle
// knot memory port sets the scan pace, the shared multiplier serves all Horner steps.
// Reset clears control and boundary count, sets knot count 2; tables: garbage until written.
// A pending result stalls only the final state; a new item is taken once idle.
module spline_layer_classifier #(
	parameter int MAX_BOUNDARIES = 8,
	parameter int MAX_KNOTS      = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         opcode,
	input  logic [3:0]         layer_index,
	input  logic [3:0]         knot_index,
	input  logic signed [31:0] x_coord,
	input  logic signed [31:0] y_coord,
	input  logic signed [31:0] coef_cubic,
	input  logic signed [31:0] coef_square,
	input  logic signed [31:0] coef_linear,
	input  logic signed [31:0] coef_const,
	input  logic signed [31:0] density_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [3:0]         layer_found,
	output logic signed [31:0] layer_density,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [4:0]         cfg_data
);
	import slc_pkg::*;

	localparam int Depth  = MAX_BOUNDARIES * MAX_KNOTS;
	localparam int AW     = $clog2(Depth);
	localparam int DD     = MAX_BOUNDARIES + 1;
	localparam int KDepth = Depth + DD;
	localparam int KAW    = $clog2(KDepth);
	localparam int KW     = $clog2(MAX_KNOTS + 1);
	localparam int BW     = $clog2(MAX_BOUNDARIES + 1);

	state_t st_q, st_d;

	logic [3:0]         bc_q;
	logic [4:0]         kc_q;
	logic [BW-1:0]      bce_q;
	logic [KW-1:0]      kce_q;
	logic [BW-1:0]      b_q;
	logic [KW-1:0]      j_q;
	logic [1:0]         h_q;
	logic               wr_q;
	logic signed [31:0] x_q, y_q, prev_q, k0_q, kseg_q;
	logic [KW-1:0]      seg_q;
	logic signed [31:0] dens_q;
	logic               out_valid_q;
	logic [3:0]         layer_out_q;
	logic signed [31:0] dens_out_q;

	logic               accept;
	logic               wr_ok;
	logic               dens_ok;
	logic [AW-1:0]      wr_addr;
	logic               knot_we;
	logic [KAW-1:0]     knot_waddr;
	logic [31:0]        knot_wdata;
	logic [KAW-1:0]     knot_raddr;
	logic [AW-1:0]      coef_raddr;
	logic signed [31:0] knot_rdata;
	logic [127:0]       coef_rdata;
	logic               bracket;
	logic               scan_end;
	logic               out_free;
	logic [BW-1:0]      bc_eff;
	logic [KW-1:0]      kc_eff;
	logic signed [31:0] t_val;
	logic signed [31:0] v_val;
	horner_ctl_t        hctl;

	assign accept   = in_valid && in_ready;
	assign in_ready = (st_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;
	assign wr_ok    = (32'(layer_index) < MAX_BOUNDARIES) && (32'(knot_index) < MAX_KNOTS);
	assign dens_ok  = (32'(layer_index) <= MAX_BOUNDARIES);
	assign wr_addr  = AW'(32'(layer_index) * MAX_KNOTS + 32'(knot_index));
	assign bracket  = (prev_q <= x_q) && (knot_rdata >= x_q);
	assign scan_end = (j_q + KW'(1)) == (kce_q - KW'(1));
	assign t_val    = sat32(64'(x_q) - 64'(kseg_q));

	assign knot_we    = accept && (((opcode == OP_WR_KNOT) && wr_ok) ||
		((opcode == OP_WR_DENS) && dens_ok));
	assign knot_waddr = (opcode == OP_WR_DENS) ? KAW'(Depth + 32'(layer_index))
		: KAW'(wr_addr);
	assign knot_wdata = (opcode == OP_WR_DENS) ? density_value : x_coord;

	always_comb begin
		int bv;
		int kv;
		bv = 32'(bc_q);
		kv = 32'(kc_q);
		if (bv > MAX_BOUNDARIES) begin
			bv = MAX_BOUNDARIES;
		end
		if (kv < 2) begin
			kv = 2;
		end
		if (kv > MAX_KNOTS) begin
			kv = MAX_KNOTS;
		end
		bc_eff = BW'(bv);
		kc_eff = KW'(kv);
	end

	slc_ram #(.WIDTH(32), .DEPTH(KDepth)) u_knot_ram (
		.clk   (clk),
		.we    (knot_we),
		.waddr (knot_waddr),
		.wdata (knot_wdata),
		.raddr (knot_raddr),
		.rdata (knot_rdata)
	);

	slc_ram #(.WIDTH(128), .DEPTH(Depth)) u_coef_ram (
		.clk   (clk),
		.we    (accept && (opcode == OP_WR_COEF) && wr_ok),
		.waddr (wr_addr),
		.wdata ({coef_cubic, coef_square, coef_linear, coef_const}),
		.raddr (coef_raddr),
		.rdata (coef_rdata)
	);

	slc_horner u_horner (
		.clk   (clk),
		.ctl   (hctl),
		.a_in  ($signed(coef_rdata[127:96])),
		.t_in  (t_val),
		.coefs (coef_rdata[95:0]),
		.v     (v_val)
	);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (accept) begin
					if (opcode != OP_QUERY) begin
						st_d = ST_DONE;
					end else if (bc_eff == '0) begin
						st_d = ST_DENS;
					end else begin
						st_d = ST_K0;
					end
				end
			end
			ST_K0:    st_d = ST_K0W;
			ST_K0W:   st_d = ST_SCAN;
			ST_SCAN: begin
				if (bracket || scan_end) begin
					st_d = ST_COEF;
				end
			end
			ST_COEF:  st_d = ST_CWAIT;
			ST_CWAIT: st_d = ST_MUL;
			ST_MUL:   st_d = ST_ADD;
			ST_ADD:   st_d = (h_q == 2'd2) ? ST_CMP : ST_MUL;
			ST_CMP: begin
				if ((v_val > y_q) && (b_q + BW'(1) != bce_q)) begin
					st_d = ST_K0;
				end else begin
					st_d = ST_DENS;
				end
			end
			ST_DENS:  st_d = ST_DWAIT;
			ST_DWAIT: st_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					st_d = ST_IDLE;
				end
			end
			default:  st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		knot_raddr = KAW'(32'(b_q) * MAX_KNOTS);
		coef_raddr = AW'(32'(b_q) * MAX_KNOTS + 32'(seg_q));
		hctl       = '0;
		unique case (st_q)
			ST_K0W:   knot_raddr = KAW'(32'(b_q) * MAX_KNOTS + 1);
			ST_SCAN:  knot_raddr = KAW'(32'(b_q) * MAX_KNOTS + 32'(j_q) + 2);
			ST_DENS:  knot_raddr = KAW'(Depth + 32'(b_q));
			ST_CWAIT: hctl.load  = 1'b1;
			ST_MUL:   hctl.mul   = 1'b1;
			ST_ADD:   hctl.add   = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			bc_q        <= '0;
			kc_q        <= 5'd2;
			out_valid_q <= 1'b0;
			b_q         <= '0;
			j_q         <= '0;
			h_q         <= '0;
			wr_q        <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				unique case (reg_index_t'(cfg_index))
					REG_BOUNDARY_COUNT: bc_q <= cfg_data[3:0];
					REG_KNOT_COUNT:     kc_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (st_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					b_q  <= '0;
					wr_q <= (opcode != OP_QUERY);
				end
				ST_K0W:  j_q <= '0;
				ST_SCAN: begin
					if (!(bracket || scan_end)) begin
						j_q <= j_q + KW'(1);
					end
				end
				ST_CWAIT: h_q <= '0;
				ST_ADD:   h_q <= h_q + 2'd1;
				ST_CMP: begin
					if (v_val > y_q) begin
						b_q <= b_q + BW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				x_q    <= x_coord;
				y_q    <= y_coord;
				bce_q  <= bc_eff;
				kce_q  <= kc_eff;
				dens_q <= '0;
			end
			ST_K0W: begin
				k0_q   <= knot_rdata;
				prev_q <= knot_rdata;
			end
			ST_SCAN: begin
				if (bracket) begin
					seg_q  <= j_q;
					kseg_q <= prev_q;
				end else if (scan_end) begin
					seg_q  <= (x_q < k0_q) ? '0 : j_q;
					kseg_q <= (x_q < k0_q) ? k0_q : prev_q;
				end else begin
					prev_q <= knot_rdata;
				end
			end
			ST_DWAIT: dens_q <= knot_rdata;
			ST_DONE: begin
				if (out_free) begin
					layer_out_q <= wr_q ? 4'd0 : 4'(b_q);
					dens_out_q  <= dens_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid     = out_valid_q;
	assign layer_found   = layer_out_q;
	assign layer_density = dens_out_q;

`ifndef SYNTHESIS
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_SCAN) |-> ((j_q + KW'(1)) < kce_q))
		else $error("knot scan past last knot");
	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CMP) |-> (b_q < bce_q))
		else $error("boundary walk past boundary count");
	a_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DONE && wr_q && out_free) |=> (layer_found == 4'd0 && layer_density == '0))
		else $error("write item produced nonzero result");
`endif
endmodule
